FILE: src/flds_pkg.sv
// Package for the flash log delta store: widths, record layouts, codes and states.
// Used by flds_ctrl, flash_log_delta_store and the testbench; depends on nothing.
`default_nettype none
package flds_pkg;

  localparam int NumKeysDef        = 256;
  localparam int SlotsPerSectorDef = 341;
  localparam int NumSectorsDef     = 16;

  localparam int SEC_W  = 4;   // sector field of an index entry
  localparam int OFF_W  = 9;   // slot-within-sector field of an index entry
  localparam int OWN_W  = 9;   // owner key stored with each record
  localparam int SEQ_W  = 32;
  localparam int DATA_W = 32;
  localparam int ID_W   = 16;

  localparam logic [OWN_W-1:0] OWNER_EMPTY = 9'h1FF;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_RESOLVE = 2'd1,
    CMD_RECOVER = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPEND,
    ST_RES_RD,
    ST_RES_IDX,
    ST_RES_LOG,
    ST_RO_RD,
    ST_RO_CHK,
    ST_RO_CPY,
    ST_ERASE,
    ST_RW_RD,
    ST_RW_CHK,
    ST_REC_CLR,
    ST_REC_RD,
    ST_REC_OWN,
    ST_REC_IDX,
    ST_REC_END,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [OWN_W-1:0]  owner;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] delta;
  } log_word_t;

  typedef struct packed {
    logic             active;
    logic [SEC_W-1:0] sector;
    logic [OFF_W-1:0] offset;
  } idx_ent_t;

  // aux holds the copied delta during rollover and the record's sequence
  // number during recovery
  typedef struct packed {
    idx_ent_t          ent;
    logic [DATA_W-1:0] aux;
  } idx_word_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] value;
  } res_t;

endpackage
`default_nettype wire

FILE: src/flds_ram.sv
// Single-port synchronous RAM with a registered read port.
// Generic; used for the log and the index of the flash log delta store.
`default_nettype none
module flds_ram #(
  parameter int Depth = 16,
  parameter int Width = 8,
  parameter int AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

FILE: src/flds_ctrl.sv
// Command sequencer of the flash log delta store: append, resolve, sector
// rollover, recovery and the power-up clearing pass. Needs flds_pkg, flds_ram.
`default_nettype none
module flds_ctrl
  import flds_pkg::*;
#(
  parameter int NumKeys        = NumKeysDef,
  parameter int SlotsPerSector = SlotsPerSectorDef,
  parameter int NumSectors     = NumSectorsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   idle_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [ID_W-1:0]   weight_id_i,
  input  wire logic [DATA_W-1:0] delta_i,
  input  wire logic [DATA_W-1:0] base_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output res_t                   res_o
);

  localparam int LogDepth = NumSectors * SlotsPerSector;
  localparam int LogAw    = $clog2(LogDepth);
  localparam int KeyW     = (NumKeys > 1) ? $clog2(NumKeys) : 1;
  localparam int ClrN     = (LogDepth > NumKeys) ? LogDepth : NumKeys;
  localparam int ClrW     = $clog2(ClrN);
  localparam int ProdW    = SEC_W + OFF_W + 1;

  localparam logic [OFF_W:0]     SlotsX    = (OFF_W+1)'(SlotsPerSector);
  localparam logic [SEC_W:0]     SectX     = (SEC_W+1)'(NumSectors);
  localparam logic [OFF_W-1:0]   LastOff   = OFF_W'(SlotsPerSector - 1);
  localparam logic [SEC_W-1:0]   LastSec   = SEC_W'(NumSectors - 1);
  localparam logic [KeyW-1:0]    LastKey   = KeyW'(NumKeys - 1);
  localparam logic [ClrW-1:0]    LastClr   = ClrW'(ClrN - 1);
  localparam logic [ClrW:0]      LogDepthX = (ClrW+1)'(LogDepth);
  localparam logic [ClrW:0]      NumKeysX  = (ClrW+1)'(NumKeys);

  function automatic logic [LogAw-1:0] slot_addr(logic [SEC_W-1:0] s, logic [OFF_W-1:0] o);
    logic [ProdW-1:0] p;
    p = ProdW'(s) * ProdW'(SlotsPerSector) + ProdW'(o);
    return p[LogAw-1:0];
  endfunction

  function automatic logic ent_ok(idx_ent_t e);
    return e.active && ({1'b0, e.sector} < SectX) && ({1'b0, e.offset} < SlotsX);
  endfunction

  state_e state_q, state_d;

  cmd_e              cmd_q, cmd_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [DATA_W-1:0] delta_q, delta_d;
  logic [DATA_W-1:0] base_q, base_d;
  logic [SEC_W-1:0]  ws_q, ws_d;
  logic [OFF_W-1:0]  wo_q, wo_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [SEC_W-1:0]  nsec_q, nsec_d;
  logic [KeyW-1:0]   k_q, k_d;
  logic [SEC_W-1:0]  rs_q, rs_d;
  logic [OFF_W-1:0]  ro_q, ro_d;
  logic              found_q, found_d;
  logic [SEQ_W-1:0]  maxseq_q, maxseq_d;
  logic [SEC_W-1:0]  msec_q, msec_d;
  logic [OFF_W-1:0]  moff_q, moff_d;
  logic [OWN_W-1:0]  own_q, own_d;
  logic [SEQ_W-1:0]  seqr_q, seqr_d;
  idx_ent_t          ent_q, ent_d;
  logic [ClrW-1:0]   clr_q, clr_d;
  logic              rok_q, rok_d;
  logic [DATA_W-1:0] rval_q, rval_d;

  logic              log_we;
  logic [LogAw-1:0]  log_addr;
  log_word_t         log_wdata, log_rdata;
  logic              idx_we;
  logic [KeyW-1:0]   idx_addr;
  idx_word_t         idx_wdata, idx_rdata;

  logic              id_ok;
  logic              wo_room;
  logic              k_last;
  logic [SEC_W-1:0]  nsec_next;
  logic [DATA_W:0]   sum;
  logic [ProdW-1:0]  key_cmp;

  assign id_ok     = weight_id_i < ID_W'(NumKeys);
  assign wo_room   = {1'b0, wo_q} < SlotsX;
  assign k_last    = (k_q == LastKey);
  assign nsec_next = (ws_q == LastSec) ? '0 : ws_q + 1'b1;
  assign sum       = {base_q[DATA_W-1], base_q} + {log_rdata.delta[DATA_W-1], log_rdata.delta};
  assign key_cmp   = ProdW'(log_rdata.owner);

  flds_ram #(
    .Depth(LogDepth),
    .Width($bits(log_word_t)),
    .AddrW(LogAw)
  ) u_log (
    .clk_i  (clk_i),
    .we_i   (log_we),
    .addr_i (log_addr),
    .wdata_i(log_wdata),
    .rdata_o(log_rdata)
  );

  flds_ram #(
    .Depth(NumKeys),
    .Width($bits(idx_word_t)),
    .AddrW(KeyW)
  ) u_idx (
    .clk_i  (clk_i),
    .we_i   (idx_we),
    .addr_i (idx_addr),
    .wdata_i(idx_wdata),
    .rdata_o(idx_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == LastClr) state_d = ST_IDLE;
      ST_IDLE: begin
        if (start_i) begin
          unique case (cmd_e'(cmd_i))
            CMD_WRITE: begin
              if (!id_ok)        state_d = ST_DONE;
              else if (!wo_room) state_d = ST_RO_RD;
              else               state_d = ST_APPEND;
            end
            CMD_RESOLVE: state_d = id_ok ? ST_RES_RD : ST_DONE;
            CMD_RECOVER: state_d = ST_REC_CLR;
            CMD_UNUSED:  state_d = ST_DONE;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_APPEND:  state_d = ST_DONE;
      ST_RES_RD:  state_d = ST_RES_IDX;
      ST_RES_IDX: state_d = ent_ok(idx_rdata.ent) ? ST_RES_LOG : ST_DONE;
      ST_RES_LOG: state_d = ST_DONE;
      ST_RO_RD:   state_d = ST_RO_CHK;
      ST_RO_CHK: begin
        if (ent_ok(idx_rdata.ent) && idx_rdata.ent.sector == nsec_q) state_d = ST_RO_CPY;
        else state_d = k_last ? ST_ERASE : ST_RO_RD;
      end
      ST_RO_CPY:  state_d = k_last ? ST_ERASE : ST_RO_RD;
      ST_ERASE: begin
        if (ro_q == LastOff) state_d = (cmd_q == CMD_RECOVER) ? ST_DONE : ST_RW_RD;
      end
      ST_RW_RD:   state_d = ST_RW_CHK;
      ST_RW_CHK:  state_d = k_last ? ST_APPEND : ST_RW_RD;
      ST_REC_CLR: if (k_last) state_d = ST_REC_RD;
      ST_REC_RD:  state_d = ST_REC_OWN;
      ST_REC_OWN: begin
        if (log_rdata.owner == OWNER_EMPTY || key_cmp >= ProdW'(NumKeys)) state_d = ST_REC_END;
        else state_d = ST_REC_IDX;
      end
      ST_REC_IDX: begin
        if (ro_q == LastOff && rs_q == LastSec) state_d = ST_REC_END;
        else state_d = ST_REC_RD;
      end
      ST_REC_END: state_d = found_q ? ST_DONE : ST_ERASE;
      ST_DONE:    if (res_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_d    = cmd_q;
    id_d     = id_q;
    delta_d  = delta_q;
    base_d   = base_q;
    ws_d     = ws_q;
    wo_d     = wo_q;
    seq_d    = seq_q;
    nsec_d   = nsec_q;
    k_d      = k_q;
    rs_d     = rs_q;
    ro_d     = ro_q;
    found_d  = found_q;
    maxseq_d = maxseq_q;
    msec_d   = msec_q;
    moff_d   = moff_q;
    own_d    = own_q;
    seqr_d   = seqr_q;
    ent_d    = ent_q;
    clr_d    = clr_q;
    rok_d    = rok_q;
    rval_d   = rval_q;

    log_we    = 1'b0;
    log_addr  = slot_addr(ws_q, wo_q);
    log_wdata = '{owner: OWN_W'(id_q), seq: seq_q, delta: delta_q};
    idx_we    = 1'b0;
    idx_addr  = k_q;
    idx_wdata = '{ent: '{active: 1'b1, sector: ws_q, offset: wo_q}, aux: '0};

    unique case (state_q)
      ST_CLEAR: begin
        // erase every slot and zero every index entry once after reset
        log_we    = {1'b0, clr_q} < LogDepthX;
        log_addr  = clr_q[LogAw-1:0];
        log_wdata = '{owner: OWNER_EMPTY, seq: '0, delta: '0};
        idx_we    = {1'b0, clr_q} < NumKeysX;
        idx_addr  = clr_q[KeyW-1:0];
        idx_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_e'(cmd_i);
          id_d    = weight_id_i;
          delta_d = delta_i;
          base_d  = base_i;
          rok_d   = 1'b0;
          rval_d  = (cmd_e'(cmd_i) == CMD_RESOLVE) ? base_i : '0;
          nsec_d  = nsec_next;
          k_d     = '0;
          ro_d    = '0;
        end
      end
      ST_APPEND: begin
        if (wo_room) begin
          log_we   = 1'b1;
          idx_we   = 1'b1;
          idx_addr = id_q[KeyW-1:0];
          seq_d    = seq_q + 1'b1;
          wo_d     = wo_q + 1'b1;
          rok_d    = 1'b1;
        end
      end
      ST_RES_RD: idx_addr = id_q[KeyW-1:0];
      ST_RES_IDX: log_addr = slot_addr(idx_rdata.ent.sector, idx_rdata.ent.offset);
      ST_RES_LOG: begin
        rok_d = 1'b1;
        if (sum[DATA_W] != sum[DATA_W-1]) begin
          rval_d = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
          rval_d = sum[DATA_W-1:0];
        end
      end
      ST_RO_RD: ;
      ST_RO_CHK: begin
        ent_d    = idx_rdata.ent;
        log_addr = slot_addr(idx_rdata.ent.sector, idx_rdata.ent.offset);
        if (!(ent_ok(idx_rdata.ent) && idx_rdata.ent.sector == nsec_q)) begin
          k_d = k_q + 1'b1;
        end
      end
      ST_RO_CPY: begin
        // park the live delta next to its key until the sector is rewritten
        idx_we    = 1'b1;
        idx_wdata = '{ent: ent_q, aux: log_rdata.delta};
        k_d       = k_q + 1'b1;
      end
      ST_ERASE: begin
        log_we    = 1'b1;
        log_addr  = slot_addr(nsec_q, ro_q);
        log_wdata = '{owner: OWNER_EMPTY, seq: '0, delta: '0};
        ro_d      = ro_q + 1'b1;
        if (ro_q == LastOff) begin
          ws_d = nsec_q;
          wo_d = '0;
          k_d  = '0;
        end
      end
      ST_RW_RD: ;
      ST_RW_CHK: begin
        if (ent_ok(idx_rdata.ent) && idx_rdata.ent.sector == nsec_q && wo_room) begin
          log_we    = 1'b1;
          log_wdata = '{owner: OWN_W'(k_q), seq: seq_q, delta: idx_rdata.aux};
          idx_we    = 1'b1;
          seq_d     = seq_q + 1'b1;
          wo_d      = wo_q + 1'b1;
        end
        k_d = k_q + 1'b1;
      end
      ST_REC_CLR: begin
        idx_we    = 1'b1;
        idx_wdata = '0;
        k_d       = k_q + 1'b1;
        rs_d      = '0;
        ro_d      = '0;
        found_d   = 1'b0;
      end
      ST_REC_RD: log_addr = slot_addr(rs_q, ro_q);
      ST_REC_OWN: begin
        idx_addr = log_rdata.owner[KeyW-1:0];
        own_d    = log_rdata.owner;
        seqr_d   = log_rdata.seq;
        if (!(log_rdata.owner == OWNER_EMPTY || key_cmp >= ProdW'(NumKeys))) begin
          if (!found_q || log_rdata.seq > maxseq_q) begin
            maxseq_d = log_rdata.seq;
            msec_d   = rs_q;
            moff_d   = ro_q + 1'b1;
            found_d  = 1'b1;
          end
        end
      end
      ST_REC_IDX: begin
        idx_addr = own_q[KeyW-1:0];
        if (!ent_ok(idx_rdata.ent) || seqr_q > idx_rdata.aux) begin
          idx_we    = 1'b1;
          idx_wdata = '{ent: '{active: 1'b1, sector: rs_q, offset: ro_q}, aux: seqr_q};
        end
        if (ro_q == LastOff) begin
          ro_d = '0;
          rs_d = rs_q + 1'b1;
        end else begin
          ro_d = ro_q + 1'b1;
        end
      end
      ST_REC_END: begin
        rok_d = 1'b1;
        if (found_q) begin
          seq_d = maxseq_q + 1'b1;
          ws_d  = msec_q;
          wo_d  = moff_q;
        end else begin
          seq_d  = '0;
          ws_d   = '0;
          wo_d   = '0;
          nsec_d = '0;
          ro_d   = '0;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ws_q    <= '0;
      wo_q    <= '0;
      seq_q   <= '0;
      k_q     <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ws_q    <= ws_d;
      wo_q    <= wo_d;
      seq_q   <= seq_d;
      k_q     <= k_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    id_q     <= id_d;
    delta_q  <= delta_d;
    base_q   <= base_d;
    nsec_q   <= nsec_d;
    rs_q     <= rs_d;
    ro_q     <= ro_d;
    maxseq_q <= maxseq_d;
    msec_q   <= msec_d;
    moff_q   <= moff_d;
    own_q    <= own_d;
    seqr_q   <= seqr_d;
    ent_q    <= ent_d;
    rok_q    <= rok_d;
    rval_q   <= rval_d;
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = '{ok: rok_q, value: rval_q};

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !log_we && !idx_we)
    else $error("memory written while idle");
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, wo_q} <= SlotsX)
    else $error("write offset past end of sector");
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ws_q} < SectX)
    else $error("write sector out of range");
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && idle_o |=> state_q != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

endmodule
`default_nettype wire

FILE: src/flash_log_delta_store.sv
// Top level of the flash log delta store: request handshake and result register.
// Needs flds_pkg and flds_ctrl (which holds the log and index RAMs).
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | input     | in_valid_i / in_ready_o | cmd_i, weight_id_i, delta_i, base_i
//  out     | output    | out_valid_o/out_ready_i | ok_o, value_o
//
// One request at a time. A write into a full sector first rolls over: a pass over
// the index that parks the live deltas of the next sector, an erase of that sector,
// and a rewrite pass over the keys. Recover clears the index, then scans the slots
// up to the first one that holds no valid key (plus one sector erase on an empty
// log). After reset a clearing pass runs through the single-ported log and index
// RAMs; in_ready_o low. A finished result waits in the output register, and the
// next request is taken while it waits.
`default_nettype none
module flash_log_delta_store
  import flds_pkg::*;
#(
  parameter int NUM_KEYS         = NumKeysDef,
  parameter int SLOTS_PER_SECTOR = SlotsPerSectorDef,
  parameter int NUM_SECTORS      = NumSectorsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [ID_W-1:0]   weight_id_i,
  input  wire logic [DATA_W-1:0] delta_i,
  input  wire logic [DATA_W-1:0] base_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   ok_o,
  output logic [DATA_W-1:0]      value_o
);

  logic start;
  logic idle;
  logic res_valid;
  logic res_ready;
  res_t res;

  logic              out_valid_q;
  logic              ok_q;
  logic [DATA_W-1:0] value_q;

  // take a request only while the sequencer is idle
  assign in_ready_o = idle;
  assign start      = in_valid_i && idle;

  // free the result slot when empty or being drained this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  flds_ctrl #(
    .NumKeys       (NUM_KEYS),
    .SlotsPerSector(SLOTS_PER_SECTOR),
    .NumSectors    (NUM_SECTORS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .idle_o     (idle),
    .cmd_i      (cmd_i),
    .weight_id_i(weight_id_i),
    .delta_i    (delta_i),
    .base_i     (base_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // hold the payload until the consumer takes it
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      ok_q    <= res.ok;
      value_q <= res.value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign value_o     = value_q;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for flash_log_delta_store: random and directed requests checked against a
// cycle-free model of the sector log and index. Depends on flds_pkg and the RTL in src.
`timescale 1ns / 1ps
module tb
  import flds_pkg::*;
;

  localparam int Keys      = NumKeysDef;
  localparam int Slots     = SlotsPerSectorDef;
  localparam int Sectors   = NumSectorsDef;
  localparam int LogDepth  = Keys > 0 ? Sectors * Slots : 1;
  localparam int StallMax  = 100000;  // cycles with no handshake before giving up
  localparam int HoldCycles = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        cmd_i = CMD_UNUSED;
  logic [ID_W-1:0]   weight_id_i = '0;
  logic [DATA_W-1:0] delta_i = '0;
  logic [DATA_W-1:0] base_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              ok_o;
  logic [DATA_W-1:0] value_o;

  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_output = 1'b0;
  int unsigned quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  flash_log_delta_store DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .weight_id_i, .delta_i, .base_i,
    .out_valid_o, .out_ready_i, .ok_o, .value_o
  );

  // Model of the log and the key index; queues the result each request must produce.
  class delta_store_tracker;
    logic [SEQ_W-1:0]  rec_seq   [LogDepth];
    logic [DATA_W-1:0] rec_delta [LogDepth];
    logic [OWN_W-1:0]  rec_owner [LogDepth];
    idx_ent_t          key_index [Keys];
    int unsigned       cur_sector, cur_offset;
    logic [SEQ_W-1:0]  seq_next;
    res_t              pending_results[$];

    function new();
      foreach (rec_owner[i]) begin
        rec_owner[i] = OWNER_EMPTY;
        rec_seq[i] = '0;
        rec_delta[i] = '0;
      end
      foreach (key_index[k]) key_index[k] = '0;
      cur_sector = 0;
      cur_offset = 0;
      seq_next = '0;
    endfunction

    function int slot_of(idx_ent_t e);
      if (!e.active || e.sector >= Sectors || e.offset >= Slots) return -1;
      return e.sector * Slots + e.offset;
    endfunction

    function void log_record(int unsigned key, logic [DATA_W-1:0] d);
      int unsigned s;
      s = cur_sector * Slots + cur_offset;
      rec_seq[s] = seq_next;
      seq_next++;
      rec_delta[s] = d;
      rec_owner[s] = key[OWN_W-1:0];
      key_index[key] = '{1'b1, cur_sector[SEC_W-1:0], cur_offset[OFF_W-1:0]};
      cur_offset++;
    endfunction

    function void wipe_sector(int unsigned sec);
      for (int o = 0; o < Slots; o++) rec_owner[sec * Slots + o] = OWNER_EMPTY;
    endfunction

    // Move to the next sector and carry its live records forward in key order.
    function void roll_sector();
      int unsigned       live_key[$];
      logic [DATA_W-1:0] live_delta[$];
      int unsigned       nsec;
      int                s;
      nsec = (cur_sector + 1 >= Sectors) ? 0 : cur_sector + 1;
      for (int k = 0; k < Keys; k++) begin
        s = slot_of(key_index[k]);
        if (s >= 0 && key_index[k].sector == nsec) begin
          live_key.push_back(k);
          live_delta.push_back(rec_delta[s]);
        end
      end
      wipe_sector(nsec);
      cur_sector = nsec;
      cur_offset = 0;
      foreach (live_key[i])
        if (cur_offset < Slots) log_record(live_key[i], live_delta[i]);
    endfunction

    function void rebuild_index();
      bit               found;
      logic [SEQ_W-1:0] top_seq;
      int unsigned      top_sec, top_off, own;
      int               s, old;
      bit               stop;
      found = 0;
      top_seq = '0;
      top_sec = 0;
      top_off = 0;
      stop = 0;
      foreach (key_index[k]) key_index[k] = '0;
      for (int sec = 0; sec < Sectors && !stop; sec++)
        for (int o = 0; o < Slots && !stop; o++) begin
          s = sec * Slots + o;
          own = rec_owner[s];
          if (own == OWNER_EMPTY || own >= Keys) stop = 1;
          else begin
            old = slot_of(key_index[own]);
            if (old < 0 || rec_seq[s] > rec_seq[old])
              key_index[own] = '{1'b1, sec[SEC_W-1:0], o[OFF_W-1:0]};
            if (!found || rec_seq[s] > top_seq) begin
              top_seq = rec_seq[s];
              top_sec = sec;
              top_off = o + 1;
              found = 1;
            end
          end
        end
      if (found) begin
        seq_next = top_seq + 1;
        cur_sector = top_sec;
        cur_offset = top_off;
      end else begin
        seq_next = '0;
        cur_sector = 0;
        cur_offset = 0;
        wipe_sector(0);
      end
    endfunction

    function void note_request(logic [1:0] cmd, logic [ID_W-1:0] id,
                               logic [DATA_W-1:0] d, logic [DATA_W-1:0] b);
      res_t    r;
      int      s;
      longint  sum;
      r = '0;
      case (cmd)
        CMD_WRITE: begin
          if (id < Keys) begin
            if (cur_offset >= Slots) roll_sector();
            if (cur_offset < Slots) begin
              log_record(id, d);
              r.ok = 1'b1;
            end
          end
        end
        CMD_RESOLVE: begin
          r.value = b;
          s = (id < Keys) ? slot_of(key_index[id]) : -1;
          if (s >= 0) begin
            sum = longint'($signed(b)) + longint'($signed(rec_delta[s]));
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            r.value = sum[31:0];
            r.ok = 1'b1;
          end
        end
        CMD_RECOVER: begin
          rebuild_index();
          r.ok = 1'b1;
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function bit check_result(logic ok, logic [DATA_W-1:0] value, output string why);
      res_t e;
      why = "";
      if (pending_results.size() == 0) begin
        why = $sformatf("unexpected result ok=%0b value=%h", ok, value);
        return 0;
      end
      e = pending_results.pop_front();
      if (ok !== e.ok) why = $sformatf("ok %b, want %b", ok, e.ok);
      else if (value !== e.value) why = $sformatf("value %h, want %h", value, e.value);
      return why == "";
    endfunction
  endclass

  delta_store_tracker store_model = new();

  task automatic report_mismatch(string why);
    fail_count++;
    $display("mismatch at %0t: %s", $time, why);
  endtask

  // Check every result that leaves the block.
  always @(posedge clk_i) begin
    string why;
    if (out_valid_o && out_ready_i)
      if (!store_model.check_result(ok_o, value_o, why)) report_mismatch(why);
  end

  // Receiver: stall at random, or hold off for a long stretch on request.
  always @(posedge clk_i) begin
    int unsigned hold_left;
    if (hold_output && hold_left == 0) begin
      hold_left = HoldCycles;
      hold_output = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles in which neither channel moves a request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallMax) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one request and hold it until the block takes it; leave valid high, or drop it for a random idle gap.
  task automatic send_request(logic [1:0] cmd, logic [ID_W-1:0] id,
                              logic [DATA_W-1:0] d, logic [DATA_W-1:0] b);
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    weight_id_i <= id;
    delta_i     <= d;
    base_i      <= b;
    do @(posedge clk_i); while (!in_ready_o);
    store_model.note_request(cmd, id, d, b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (store_model.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_request(int unsigned key_span);
    int unsigned       pick;
    logic [1:0]        cmd;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] b;
    pick = $urandom_range(999);
    if (pick < 700) cmd = CMD_WRITE;
    else if (pick < 950) cmd = CMD_RESOLVE;
    else if (pick < 960) cmd = CMD_RECOVER;
    else cmd = CMD_UNUSED;
    id = ($urandom_range(99) < 85) ? ID_W'($urandom_range(key_span))
                                   : ID_W'($urandom_range(65535));
    case ($urandom_range(9))
      0: b = 32'h7FFF_FFFF;
      1: b = 32'h8000_0000;
      default: b = $urandom;
    endcase
    send_request(cmd, id, $urandom, b);
  endtask

  initial begin
    int unsigned span;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-log recover, key extremes, refused keys, saturation, unused command.
    send_request(CMD_RECOVER, 16'd0, 32'h0, 32'h0);
    send_request(CMD_RESOLVE, 16'd5, 32'h0, 32'h1234_5678);
    send_request(CMD_WRITE, 16'd0, 32'h7FFF_FFFF, 32'h0);
    send_request(CMD_WRITE, 16'd255, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(CMD_WRITE, 16'd256, 32'h1, 32'h0);
    send_request(CMD_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    send_request(CMD_RESOLVE, 16'd0, 32'h0, 32'h7FFF_FFFF);
    send_request(CMD_RESOLVE, 16'd0, 32'h0, 32'h8000_0000);
    send_request(CMD_RESOLVE, 16'd255, 32'h0, 32'h8000_0000);
    send_request(CMD_RESOLVE, 16'd255, 32'h0, 32'h7FFF_FFFF);
    send_request(CMD_RESOLVE, 16'd256, 32'h0, 32'hDEAD_BEEF);
    send_request(CMD_RESOLVE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_UNUSED, 16'd0, 32'h0, 32'h0);
    send_request(CMD_WRITE, 16'd0, 32'h0001_0000, 32'h0);
    send_request(CMD_RECOVER, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_RESOLVE, 16'd0, 32'h0, 32'h0000_8000);
    send_request(CMD_RESOLVE, 16'd255, 32'h0, 32'h0);
    send_request(CMD_WRITE, 16'd7, 32'h1234_5678, 32'h0);
    drain_results();

    // Random, three idling phases; hold off the receiver once in the first.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 30 : 0;
      for (int n = 0; n < 350; n++) begin
        if (phase == 0 && n == 40) hold_output = 1'b1;
        // Narrow key sets keep many records live across a rollover.
        if (n % 100 == 0) span = ($urandom_range(1)) ? 15 : Keys - 1;
        random_request(span);
      end
      drain_results();
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && store_model.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
